>>> src/sks_pkg.sv
// Shared types, constants and the process noise table of the scalar Kalman smoother.
package sks_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GAIN_BITS = 24;
	localparam int DATA_W    = 32;
	localparam int GAIN_W    = GAIN_BITS + 1;
	localparam int LEVEL_W   = 4;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS     = 2'd2;

	localparam logic [DATA_W-1:0]  ERR_ONE    = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(64'd1 << GAIN_BITS);
	localparam logic [LEVEL_W-1:0] SENS_RESET = 4'd11;

	// Divider: one quotient bit per cycle
	localparam int DIV_STEPS = GAIN_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int DEN_W     = DATA_W + 1;
	localparam int REM_W     = DATA_W + 2;

	// Shared multiplier: 25 x 16, two partial products per 32-bit operand
	localparam int MUL_B_W = DATA_W / 2;
	localparam int MUL_P_W = GAIN_W + MUL_B_W;
	localparam int ACC_W   = GAIN_W + DATA_W;

	// Multiplier operand selection
	localparam logic [1:0] MSRC_CORR = 2'd0;
	localparam logic [1:0] MSRC_KEEP = 2'd1;
	localparam logic [1:0] MSRC_ADD  = 2'd2;

	// Accumulator operations
	localparam logic [1:0] ACC_HOLD   = 2'd0;
	localparam logic [1:0] ACC_LOAD   = 2'd1;
	localparam logic [1:0] ACC_ADD_HI = 2'd2;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic [1:0] mul_src;
		logic       mul_hi;
		logic [1:0] acc_op;
		logic       round;
		logic       est;
		logic       keep_save;
		logic       fin;
	} sks_cmd_t;

	// Process noise q, Q1.24, by sensitivity level
	function automatic logic [GAIN_W-1:0] q_factor(input logic [LEVEL_W-1:0] level);
		logic [GAIN_W-1:0] q;
		unique case (level)
			4'd0:    q = 25'd16777216;
			4'd1:    q = 25'd15099494;
			4'd2:    q = 25'd13421773;
			4'd3:    q = 25'd11744051;
			4'd4:    q = 25'd10066330;
			4'd5:    q = 25'd8388608;
			4'd6:    q = 25'd6710886;
			4'd7:    q = 25'd5872026;
			4'd8:    q = 25'd5033165;
			4'd9:    q = 25'd4194304;
			4'd10:   q = 25'd3355443;
			4'd11:   q = 25'd1677722;
			4'd12:   q = 25'd167772;
			4'd13:   q = 25'd16777;
			4'd14:   q = 25'd1678;
			default: q = 25'd1677722;
		endcase
		return q;
	endfunction

endpackage

>>> src/sks_ctrl.sv
// Sequencer of the smoother: handshakes, divider count and datapath commands.
module sks_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output sks_pkg::sks_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV   = 4'd1;
	localparam logic [3:0] ST_P_LO  = 4'd2;
	localparam logic [3:0] ST_P_HI  = 4'd3;
	localparam logic [3:0] ST_P_ACC = 4'd4;
	localparam logic [3:0] ST_RND   = 4'd5;
	localparam logic [3:0] ST_K_LO  = 4'd6;
	localparam logic [3:0] ST_K_HI  = 4'd7;
	localparam logic [3:0] ST_K_ACC = 4'd8;
	localparam logic [3:0] ST_A_LO  = 4'd9;
	localparam logic [3:0] ST_A_HI  = 4'd10;
	localparam logic [3:0] ST_A_ACC = 4'd11;
	localparam logic [3:0] ST_FIN   = 4'd12;

	logic [3:0]               state_q, state_d;
	logic [sks_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                     out_valid_q;
	logic                     out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		cmd.mul_src = sks_pkg::MSRC_CORR;
		cmd.acc_op  = sks_pkg::ACC_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == sks_pkg::CNT_W'(sks_pkg::DIV_STEPS - 1)) begin
					state_d = ST_P_LO;
				end
			end
			ST_P_LO: begin
				state_d = ST_P_HI;
			end
			ST_P_HI: begin
				cmd.mul_hi = 1'b1;
				cmd.acc_op = sks_pkg::ACC_LOAD;
				state_d    = ST_P_ACC;
			end
			ST_P_ACC: begin
				cmd.acc_op = sks_pkg::ACC_ADD_HI;
				state_d    = ST_RND;
			end
			ST_RND: begin
				cmd.round = 1'b1;
				state_d   = ST_K_LO;
			end
			ST_K_LO: begin
				cmd.mul_src = sks_pkg::MSRC_KEEP;
				cmd.est     = 1'b1;
				state_d     = ST_K_HI;
			end
			ST_K_HI: begin
				cmd.mul_src = sks_pkg::MSRC_KEEP;
				cmd.mul_hi  = 1'b1;
				cmd.acc_op  = sks_pkg::ACC_LOAD;
				state_d     = ST_K_ACC;
			end
			ST_K_ACC: begin
				cmd.acc_op = sks_pkg::ACC_ADD_HI;
				state_d    = ST_A_LO;
			end
			ST_A_LO: begin
				cmd.mul_src   = sks_pkg::MSRC_ADD;
				cmd.keep_save = 1'b1;
				state_d       = ST_A_HI;
			end
			ST_A_HI: begin
				cmd.mul_src = sks_pkg::MSRC_ADD;
				cmd.mul_hi  = 1'b1;
				cmd.acc_op  = sks_pkg::ACC_LOAD;
				state_d     = ST_A_ACC;
			end
			ST_A_ACC: begin
				cmd.acc_op = sks_pkg::ACC_ADD_HI;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to free up
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/sks_datapath.sv
// Datapath of the smoother: state, configuration, radix-2 divider, shared multiplier.
module sks_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sks_pkg::sks_cmd_t                 cmd,
	input  logic signed [sks_pkg::DATA_W-1:0] measurement,
	input  logic                              cfg_write_en,
	input  logic [sks_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sks_pkg::DATA_W-1:0]        cfg_data,
	output logic signed [sks_pkg::DATA_W-1:0] estimate,
	output logic [sks_pkg::GAIN_W-1:0]        gain,
	output logic [sks_pkg::DATA_W-1:0]        estimate_error
);

	// Configuration and filter state
	logic [sks_pkg::DATA_W-1:0]  meas_err_q;
	logic [sks_pkg::LEVEL_W-1:0] level_q;
	logic [sks_pkg::DATA_W-1:0]  err_q;
	logic [sks_pkg::DATA_W-1:0]  prior_q;

	// Per-transaction working registers
	logic [sks_pkg::DATA_W-1:0]  mag_q;
	logic                        neg_q;
	logic [sks_pkg::DEN_W-1:0]   den_q;
	logic                        zero_den_q;
	logic [sks_pkg::REM_W-1:0]   rem_q;
	logic [sks_pkg::GAIN_W-1:0]  quo_q;
	logic [sks_pkg::MUL_P_W-1:0] prod_q;
	logic [sks_pkg::ACC_W-1:0]   acc_q;
	logic [sks_pkg::DATA_W-1:0]  t_q;
	logic [sks_pkg::DATA_W-1:0]  est_q;
	logic [sks_pkg::DATA_W-1:0]  keep_q;
	logic [sks_pkg::GAIN_W-1:0]  gain_out_q;

	logic [sks_pkg::DATA_W:0]    diff;
	logic [sks_pkg::DATA_W:0]    mag;
	logic [sks_pkg::DEN_W-1:0]   den;
	logic [sks_pkg::REM_W-1:0]   rem_sub;
	logic [sks_pkg::REM_W-1:0]   rem_next;
	logic                        rem_ge;
	logic [sks_pkg::GAIN_W-1:0]  gain_w;
	logic [sks_pkg::GAIN_W-1:0]  mul_a;
	logic [sks_pkg::DATA_W-1:0]  mul_b_full;
	logic [sks_pkg::MUL_B_W-1:0] mul_b;
	logic [sks_pkg::ACC_W-1:0]   rnd_sum;
	logic [sks_pkg::DATA_W:0]    added;
	logic [sks_pkg::DATA_W+1:0]  err_sum;
	logic [sks_pkg::DATA_W-1:0]  err_sat;

	// Innovation magnitude and sign, denominator
	always_comb begin
		diff = {measurement[sks_pkg::DATA_W-1], measurement} - {prior_q[sks_pkg::DATA_W-1], prior_q};
		mag  = diff[sks_pkg::DATA_W] ? ((sks_pkg::DATA_W+1)'(0) - diff) : diff;
		den  = {1'b0, err_q} + {1'b0, meas_err_q};
	end

	// Restoring division step
	always_comb begin
		rem_ge   = rem_q >= {1'b0, den_q};
		rem_sub  = rem_q - {1'b0, den_q};
		rem_next = rem_ge ? rem_sub : rem_q;
	end

	assign gain_w = zero_den_q ? '0 : quo_q;

	// Multiplier operand selection
	always_comb begin
		case (cmd.mul_src)
			sks_pkg::MSRC_CORR: begin
				mul_a      = gain_w;
				mul_b_full = mag_q;
			end
			sks_pkg::MSRC_KEEP: begin
				mul_a      = sks_pkg::GAIN_ONE - gain_w;
				mul_b_full = err_q;
			end
			sks_pkg::MSRC_ADD: begin
				mul_a      = sks_pkg::q_factor(level_q);
				mul_b_full = t_q;
			end
			default: begin
				mul_a      = '0;
				mul_b_full = '0;
			end
		endcase
		mul_b = cmd.mul_hi ? mul_b_full[sks_pkg::DATA_W-1:sks_pkg::MUL_B_W]
		                   : mul_b_full[sks_pkg::MUL_B_W-1:0];
	end

	// Floor for a positive correction, ceiling of the magnitude for a negative one
	assign rnd_sum = acc_q + (neg_q ? (sks_pkg::ACC_W'(sks_pkg::GAIN_ONE) - 1'b1) : '0);

	// Error update with saturation
	always_comb begin
		added   = (sks_pkg::DATA_W+1)'(acc_q >> sks_pkg::GAIN_BITS);
		err_sum = {2'b00, keep_q} + {1'b0, added};
		err_sat = (|err_sum[sks_pkg::DATA_W+1:sks_pkg::DATA_W]) ? '1
		                                                       : err_sum[sks_pkg::DATA_W-1:0];
	end

	// Configuration and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_err_q <= sks_pkg::ERR_ONE;
			level_q    <= sks_pkg::SENS_RESET;
			err_q      <= sks_pkg::ERR_ONE;
			prior_q    <= '0;
		end else begin
			if (cfg_write_en && (cfg_index == sks_pkg::REG_MEAS_ERR)) begin
				meas_err_q <= cfg_data;
			end
			if (cfg_write_en && (cfg_index == sks_pkg::REG_SENS)) begin
				level_q <= cfg_data[sks_pkg::LEVEL_W-1:0];
			end
			if (cfg_write_en && (cfg_index == sks_pkg::REG_INIT_ERR)) begin
				err_q <= cfg_data;
			end else if (cmd.fin) begin
				err_q <= err_sat;
			end
			if (cmd.fin) begin
				prior_q <= est_q;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q      <= mag[sks_pkg::DATA_W-1:0];
			neg_q      <= diff[sks_pkg::DATA_W];
			den_q      <= den;
			zero_den_q <= (den == '0);
			rem_q      <= sks_pkg::REM_W'(err_q);
			quo_q      <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {rem_next[sks_pkg::REM_W-2:0], 1'b0};
			quo_q <= {quo_q[sks_pkg::GAIN_W-2:0], rem_ge};
		end

		prod_q <= mul_a * mul_b;

		case (cmd.acc_op)
			sks_pkg::ACC_LOAD:   acc_q <= sks_pkg::ACC_W'(prod_q);
			sks_pkg::ACC_ADD_HI: acc_q <= acc_q + (sks_pkg::ACC_W'(prod_q) << sks_pkg::MUL_B_W);
			default:             acc_q <= acc_q;
		endcase

		if (cmd.round) begin
			t_q <= sks_pkg::DATA_W'(rnd_sum >> sks_pkg::GAIN_BITS);
		end
		if (cmd.est) begin
			est_q <= neg_q ? (prior_q - t_q) : (prior_q + t_q);
		end
		if (cmd.keep_save) begin
			keep_q <= sks_pkg::DATA_W'(acc_q >> sks_pkg::GAIN_BITS);
		end
		if (cmd.fin) begin
			gain_out_q <= gain_w;
		end
	end

	// The state registers double as the held estimate and error; the gain has its own register
	assign estimate       = $signed(prior_q);
	assign estimate_error = err_q;
	assign gain           = gain_out_q;

endmodule

>>> src/scalar_kalman_smoother_top.sv
// Top level of the scalar Kalman smoother: sequencer, datapath and checks.
// Sequence of a transaction: 25 radix-2 gain divider steps, then the correction product,
// rounding, and the keep and add products on the shared 25 x 16 multiplier, then a finish
// that waits for the output register to free up; a new sample is taken only in idle.
// A finished result waits in the output register while the next sample is taken.
// Reset: asynchronous, estimate 0, error 1.0, configuration reset values; no clearing pass.
module scalar_kalman_smoother_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [sks_pkg::DATA_W-1:0] measurement,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [sks_pkg::DATA_W-1:0] estimate,
	output logic [sks_pkg::GAIN_W-1:0]        gain,
	output logic [sks_pkg::DATA_W-1:0]        estimate_error,
	input  logic                              cfg_write_en,
	input  logic [sks_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sks_pkg::DATA_W-1:0]        cfg_data
);

	sks_pkg::sks_cmd_t cmd;

	sks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sks_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.measurement    (measurement),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.estimate       (estimate),
		.gain           (gain),
		.estimate_error (estimate_error)
	);

	// One transaction in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a transaction is in progress");

	// Gain never exceeds 1.0
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain <= sks_pkg::GAIN_ONE)
		else $error("gain above 1.0");

	// A new result only appears at the end of a busy sequence
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result produced without a transaction");

endmodule
